[rtl/igt_pkg.sv]
// Shared types, constants and the arctangent angle table for the IMU
// gyro integration and accelerometer tilt block. No dependencies.
`default_nettype none
package igt_pkg;

	localparam int SMP_W     = 16;
	localparam int GAIN_W    = 32;
	localparam int ACC_W     = 40;
	localparam int TILT_W    = 16;
	localparam int MAG_W     = 15;
	localparam int ANG_W     = 22;
	localparam int MAX_STEPS = 24;
	localparam int STEP_W    = 5;

	localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd261888;
	localparam logic [MAG_W-1:0]  QUARTER_TURN = 15'd23040;
	localparam logic [23:0]       ANG90_Q16    = 24'd5898240;

	// One input transaction: three accelerometer and three gyro samples
	typedef struct packed {
		logic signed [SMP_W-1:0] accel_x;
		logic signed [SMP_W-1:0] accel_y;
		logic signed [SMP_W-1:0] accel_z;
		logic signed [SMP_W-1:0] rate_x;
		logic signed [SMP_W-1:0] rate_y;
		logic signed [SMP_W-1:0] rate_z;
	} igt_in_t;

	// One output transaction
	typedef struct packed {
		logic signed [ACC_W-1:0]  roll_integrated;
		logic signed [ACC_W-1:0]  pitch_integrated;
		logic signed [ACC_W-1:0]  yaw_integrated;
		logic signed [TILT_W-1:0] roll_tilt;
		logic signed [TILT_W-1:0] pitch_tilt;
		logic signed [TILT_W-1:0] yaw_tilt;
	} igt_out_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0:    a = 22'd2949120;
			5'd1:    a = 22'd1740967;
			5'd2:    a = 22'd919879;
			5'd3:    a = 22'd466945;
			5'd4:    a = 22'd234379;
			5'd5:    a = 22'd117305;
			5'd6:    a = 22'd58666;
			5'd7:    a = 22'd29335;
			5'd8:    a = 22'd14668;
			5'd9:    a = 22'd7334;
			5'd10:   a = 22'd3667;
			5'd11:   a = 22'd1833;
			5'd12:   a = 22'd917;
			5'd13:   a = 22'd458;
			5'd14:   a = 22'd229;
			5'd15:   a = 22'd115;
			5'd16:   a = 22'd57;
			5'd17:   a = 22'd29;
			5'd18:   a = 22'd14;
			5'd19:   a = 22'd7;
			5'd20:   a = 22'd4;
			5'd21:   a = 22'd2;
			5'd22:   a = 22'd1;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[rtl/igt_integ.sv]
// Gyro rate integrator: one shared 16x32 multiplier and saturating adder
// walk the three axes in turn. Depends on igt_pkg.
`default_nettype none
module igt_integ
	import igt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [GAIN_W-1:0]        gain,
	input  wire logic signed [SMP_W-1:0]  rate_x,
	input  wire logic signed [SMP_W-1:0]  rate_y,
	input  wire logic signed [SMP_W-1:0]  rate_z,
	output logic signed [ACC_W-1:0]       acc_x,
	output logic signed [ACC_W-1:0]       acc_y,
	output logic signed [ACC_W-1:0]       acc_z,
	output logic                          busy
);

	localparam int PROD_W = SMP_W + GAIN_W + 1;
	localparam int INC_W  = PROD_W - 16;

	logic [1:0]               cnt_q;
	logic                     run_q;
	logic                     valid_s1;
	logic [1:0]               axis_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q [3];

	logic signed [SMP_W-1:0]  raw_sel;
	logic signed [INC_W-1:0]  inc;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W-1:0]  acc_cur;
	logic signed [ACC_W-1:0]  acc_new;

	// operand select for the shared multiplier
	always_comb begin
		case (cnt_q)
			2'd0:    raw_sel = rate_x;
			2'd1:    raw_sel = rate_y;
			default: raw_sel = rate_z;
		endcase
	end

	// floor shift by 16, then saturating add
	always_comb begin
		inc     = prod_s1[PROD_W-1:16];
		acc_cur = acc_q[axis_s1];
		sum     = {acc_cur[ACC_W-1], acc_cur} + (ACC_W+1)'(inc);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_new = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_new = sum[ACC_W-1:0];
		end
	end

	// axis counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= run_q;
			if (start) begin
				cnt_q <= 2'd0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (run_q) begin
			prod_s1 <= PROD_W'(raw_sel) * $signed({1'b0, gain});
			axis_s1 <= cnt_q;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end else if (valid_s1) begin
			acc_q[axis_s1] <= acc_new;
		end
	end

	assign acc_x = acc_q[0];
	assign acc_y = acc_q[1];
	assign acc_z = acc_q[2];
	assign busy  = run_q | valid_s1;

endmodule
`default_nettype wire

[rtl/igt_cordic.sv]
// Vectoring CORDIC arctangent, one iteration per cycle on a shared
// add/shift unit. Depends on igt_pkg.
`default_nettype none
module igt_cordic
	import igt_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [SMP_W-1:0]  num,
	input  wire logic signed [SMP_W-1:0]  den,
	output logic                          done,
	output logic [MAG_W-1:0]              mag,
	output logic                          neg
);

	localparam int EFF_STEPS = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
	localparam logic [STEP_W-1:0] LAST = STEP_W'(EFF_STEPS - 1);
	localparam int XW = 33;
	localparam int ZW = 25;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RUN  = 2'd1;
	localparam logic [1:0] C_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [STEP_W-1:0]     i_q;
	logic signed [XW-1:0]  x_q;
	logic signed [XW-1:0]  y_q;
	logic signed [ZW-1:0]  z_q;
	logic [MAG_W-1:0]      mag_q;
	logic                  neg_q;
	logic                  done_q;

	logic signed [SMP_W:0] num_w;
	logic signed [SMP_W:0] den_w;
	logic signed [SMP_W:0] num_abs;
	logic signed [SMP_W:0] den_abs;
	logic signed [XW-1:0]  xs;
	logic signed [XW-1:0]  ys;
	logic signed [XW-1:0]  x_n;
	logic signed [XW-1:0]  y_n;
	logic signed [ZW-1:0]  z_n;
	logic signed [ZW-1:0]  step_ang;
	logic [23:0]           z_clamp;
	logic [23:0]           z_round;

	// operand folding
	always_comb begin
		num_w   = {num[SMP_W-1], num};
		den_w   = {den[SMP_W-1], den};
		num_abs = num_w[SMP_W] ? -num_w : num_w;
		den_abs = den_w[SMP_W] ? -den_w : den_w;
	end

	// one micro-rotation
	always_comb begin
		xs       = x_q >>> i_q;
		ys       = y_q >>> i_q;
		step_ang = ZW'(atan_entry(i_q));
		if (!y_q[XW-1]) begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + step_ang;
		end else begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - step_ang;
		end
	end

	// clamp to 0..90 degrees, round half up to 2^-8 degree
	always_comb begin
		if (z_q[ZW-1]) begin
			z_clamp = '0;
		end else if (z_q[23:0] > ANG90_Q16) begin
			z_clamp = ANG90_Q16;
		end else begin
			z_clamp = z_q[23:0];
		end
		z_round = z_clamp + 24'd128;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						if (den == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= C_RUN;
						end
					end
				end
				C_RUN: begin
					if (i_q == LAST) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			neg_q <= num[SMP_W-1] ^ den[SMP_W-1];
			mag_q <= (num == '0) ? '0 : QUARTER_TURN;
			x_q   <= XW'(den_abs) <<< 14;
			y_q   <= XW'(num_abs) <<< 14;
			z_q   <= '0;
			i_q   <= '0;
		end else if (state_q == C_RUN) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			i_q <= i_q + STEP_W'(1);
		end else if (state_q == C_FIN) begin
			mag_q <= z_round[22:8];
		end
	end

	assign done = done_q;
	assign mag  = mag_q;
	assign neg  = neg_q;

endmodule
`default_nettype wire

[rtl/imu_gyro_integrate_accel_tilt.sv]
// IMU gyro integration and accelerometer tilt, top level: register,
// sequencer and output register. Depends on igt_pkg, igt_integ, igt_cordic.
//
// Usage:
//   in_valid/in_ready/in_data carries one sample tick (three accel, three
//   gyro readings). out_valid/out_ready/out_data returns one result per tick:
//   the three gyro angle accumulators after the update and the roll, pitch
//   and yaw tilt angles from the accelerometer.
//   cfg_valid/cfg_ready/cfg_data writes the gyro gain; cfg_ready is always
//   high, and the gain must only change while the block is idle.
// Sequencing:
//   A result is loaded once the yaw angle is done, the integrator is idle and the output
//   register is free; the next tick can be accepted in the cycle after that load. A zero
//   denominator cuts an angle short, with no iterations. The three arctangents run one after
//   another on a single CORDIC unit, one iteration per cycle; the gyro axes share one
//   multiplier alongside them. in_ready is high only while no tick is in progress.
// Reset and stall:
//   arst_n clears the accumulators, restores the default gain and empties
//   the output register. A finished result stays in the output register
//   while out_ready is low; a new tick may be accepted meanwhile and waits
//   at its end until the register frees.
`default_nettype none
module imu_gyro_integrate_accel_tilt
	import igt_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [GAIN_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire igt_in_t           in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output igt_out_t               out_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROLL  = 3'd1;
	localparam logic [2:0] S_PITCH = 3'd2;
	localparam logic [2:0] S_YAW   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]               state_q;
	logic                     start_q;
	logic [GAIN_W-1:0]        gain_q;
	igt_in_t                  smp_q;
	logic signed [TILT_W-1:0] roll_q;
	logic signed [TILT_W-1:0] pitch_q;
	logic signed [TILT_W-1:0] yaw_q;
	igt_out_t                 out_q;
	logic                     out_valid_q;

	logic                     in_fire;
	logic                     out_load;
	logic signed [SMP_W-1:0]  c_num;
	logic signed [SMP_W-1:0]  c_den;
	logic                     c_done;
	logic [MAG_W-1:0]         c_mag;
	logic                     c_neg;
	logic signed [TILT_W-1:0] c_pos;
	logic signed [TILT_W-1:0] c_ang;
	logic signed [ACC_W-1:0]  acc_x;
	logic signed [ACC_W-1:0]  acc_y;
	logic signed [ACC_W-1:0]  acc_z;
	logic                     integ_busy;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_DONE) && !integ_busy && (!out_valid_q || out_ready);

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			smp_q <= in_data;
		end
	end

	// CORDIC operand select by angle
	always_comb begin
		case (state_q)
			S_PITCH: begin
				c_num = smp_q.accel_x;
				c_den = smp_q.accel_z;
			end
			S_YAW: begin
				c_num = smp_q.accel_y;
				c_den = smp_q.accel_x;
			end
			default: begin
				c_num = smp_q.accel_y;
				c_den = smp_q.accel_z;
			end
		endcase
	end

	// signed angle from magnitude and quadrant
	always_comb begin
		c_pos = {1'b0, c_mag};
		c_ang = c_neg ? -c_pos : c_pos;
	end

	igt_integ u_integ (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.gain   (gain_q),
		.rate_x (smp_q.rate_x),
		.rate_y (smp_q.rate_y),
		.rate_z (smp_q.rate_z),
		.acc_x  (acc_x),
		.acc_y  (acc_y),
		.acc_z  (acc_z),
		.busy   (integ_busy)
	);

	igt_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (c_num),
		.den    (c_den),
		.done   (c_done),
		.mag    (c_mag),
		.neg    (c_neg)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_ROLL;
						start_q <= 1'b1;
					end
				end
				S_ROLL: begin
					if (c_done) begin
						state_q <= S_PITCH;
						start_q <= 1'b1;
					end
				end
				S_PITCH: begin
					if (c_done) begin
						state_q <= S_YAW;
						start_q <= 1'b1;
					end
				end
				S_YAW: begin
					if (c_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tilt results; pitch is the negated angle
	always_ff @(posedge clk) begin
		if (c_done) begin
			case (state_q)
				S_ROLL:  roll_q  <= c_ang;
				S_PITCH: pitch_q <= -c_ang;
				S_YAW:   yaw_q   <= c_ang;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.roll_integrated  <= acc_x;
			out_q.pitch_integrated <= acc_y;
			out_q.yaw_integrated   <= acc_z;
			out_q.roll_tilt        <= roll_q;
			out_q.pitch_tilt       <= pitch_q;
			out_q.yaw_tilt         <= yaw_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted while a tick is still in progress");

	a_done_in_angle_state: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == S_ROLL || state_q == S_PITCH || state_q == S_YAW))
		else $error("CORDIC finished outside an angle evaluation");

	a_integ_quiet_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !integ_busy)
		else $error("integrator still busy with the sequencer idle");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.roll_tilt <= 16'sd23040 && out_data.roll_tilt >= -16'sd23040
			&& out_data.yaw_tilt <= 16'sd23040 && out_data.yaw_tilt >= -16'sd23040))
		else $error("tilt angle beyond a quarter turn");
`endif

endmodule
`default_nettype wire

[sim/tb_imu_gyro_integrate_accel_tilt.sv]
// Testbench for imu_gyro_integrate_accel_tilt: gyro angle accumulation and
// accelerometer CORDIC tilt angles, checked against a built-in predictor.
// Depends on igt_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_imu_gyro_integrate_accel_tilt;
	import igt_pkg::*;

	localparam int     STEPS         = 16;
	localparam int     IDLE_LIMIT    = 5000;
	localparam int     SETTLE_CYCLES = 80;
	localparam longint ACC_HI        = 64'sd549755813887;
	localparam longint ACC_LO        = -ACC_HI - 1;
	localparam longint RIGHT_ANGLE   = 23040;
	localparam longint ANG90         = 5898240;

	// atan(2^-i), units of 2^-16 degree
	localparam longint ATAN_Q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	// Rate bias used to push the accumulators into saturation
	typedef enum int {
		DRIFT_DOWN = -1,
		DRIFT_NONE = 0,
		DRIFT_UP   = 1
	} drift_e;

	// Tracks gain and accumulators, queues expected angles, checks results
	class angle_predictor;
		logic [GAIN_W-1:0] gain;
		longint            roll_acc;
		longint            pitch_acc;
		longint            yaw_acc;
		igt_out_t          pending_angles[$];
		int                mismatches;

		function new();
			gain       = GAIN_RESET;
			roll_acc   = 0;
			pitch_acc  = 0;
			yaw_acc    = 0;
			mismatches = 0;
		endfunction

		function void set_gain(logic [GAIN_W-1:0] g);
			gain = g;
		endfunction

		function int pending();
			return pending_angles.size();
		endfunction

		// floor(rate * gain / 2^16), added with 40-bit saturation
		function longint integrate_rate(longint acc, logic signed [SMP_W-1:0] rate);
			longint step;
			longint sum;
			step = (longint'(rate) * longint'(gain)) >>> 16;
			sum  = acc + step;
			if (sum > ACC_HI) sum = ACC_HI;
			if (sum < ACC_LO) sum = ACC_LO;
			return sum;
		endfunction

		// atan(num/den) in units of 2^-8 degree, vectoring CORDIC on magnitudes
		function longint tilt_q8(longint num, longint den);
			bit     flip;
			longint x;
			longint y;
			longint z;
			longint xs;
			longint ys;
			longint r;
			if (den == 0) begin
				if (num > 0) return RIGHT_ANGLE;
				if (num < 0) return -RIGHT_ANGLE;
				return 0;
			end
			flip = (num < 0) != (den < 0);
			x = (den < 0 ? -den : den) * 16384;
			y = (num < 0 ? -num : num) * 16384;
			z = 0;
			for (int i = 0; i < STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys;
					y -= xs;
					z += ATAN_Q16[i];
				end else begin
					x -= ys;
					y += xs;
					z -= ATAN_Q16[i];
				end
			end
			if (z < 0) z = 0;
			if (z > ANG90) z = ANG90;
			r = (z + 128) >>> 8;
			return flip ? -r : r;
		endfunction

		function void note_sample(igt_in_t s);
			igt_out_t want;
			longint   ang;
			roll_acc  = integrate_rate(roll_acc, s.rate_x);
			pitch_acc = integrate_rate(pitch_acc, s.rate_y);
			yaw_acc   = integrate_rate(yaw_acc, s.rate_z);
			want.roll_integrated  = roll_acc[ACC_W-1:0];
			want.pitch_integrated = pitch_acc[ACC_W-1:0];
			want.yaw_integrated   = yaw_acc[ACC_W-1:0];
			ang = tilt_q8(s.accel_y, s.accel_z);
			want.roll_tilt = ang[TILT_W-1:0];
			ang = -tilt_q8(s.accel_x, s.accel_z);
			want.pitch_tilt = ang[TILT_W-1:0];
			ang = tilt_q8(s.accel_y, s.accel_x);
			want.yaw_tilt = ang[TILT_W-1:0];
			pending_angles.push_back(want);
		endfunction

		function void report_mismatch(string field, longint want, longint seen);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, seen);
		endfunction

		function void check_angles(igt_out_t got);
			igt_out_t want;
			if (pending_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result with no transaction pending: %p", $time, got);
				return;
			end
			want = pending_angles.pop_front();
			if (got.roll_integrated !== want.roll_integrated)
				report_mismatch("roll_integrated", want.roll_integrated, got.roll_integrated);
			if (got.pitch_integrated !== want.pitch_integrated)
				report_mismatch("pitch_integrated", want.pitch_integrated, got.pitch_integrated);
			if (got.yaw_integrated !== want.yaw_integrated)
				report_mismatch("yaw_integrated", want.yaw_integrated, got.yaw_integrated);
			if (got.roll_tilt !== want.roll_tilt)
				report_mismatch("roll_tilt", want.roll_tilt, got.roll_tilt);
			if (got.pitch_tilt !== want.pitch_tilt)
				report_mismatch("pitch_tilt", want.pitch_tilt, got.pitch_tilt);
			if (got.yaw_tilt !== want.yaw_tilt)
				report_mismatch("yaw_tilt", want.yaw_tilt, got.yaw_tilt);
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [GAIN_W-1:0] cfg_data  = '0;
	logic              in_valid  = 1'b0;
	igt_in_t           in_data   = '0;
	logic              out_ready = 1'b0;
	wire               cfg_ready;
	wire               in_ready;
	wire               out_valid;
	igt_out_t          out_data;

	angle_predictor    pred;
	int                idle_cycles = 0;
	int                ready_mode  = 0;
	int                ready_left  = 0;

	imu_gyro_integrate_accel_tilt #(
		.CORDIC_STEPS(STEPS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Transaction monitor: gain writes, accepted samples, returned angles
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) pred.set_gain(cfg_data);
			if (in_valid && in_ready) pred.note_sample(in_data);
			if (out_valid && out_ready) pred.check_angles(out_data);
		end
	end

	// Watchdog: too long with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver backpressure: always ready, coin flip, mostly stalled, periodic
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 150);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (ready_left % 3 != 0);
		endcase
	end

	function automatic logic signed [SMP_W-1:0] random_reading();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return '0;
			1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2:       return 16'(int'($urandom_range(0, 8)) - 4);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] rate_reading(drift_e drift);
		if (drift != DRIFT_NONE && $urandom_range(0, 9) != 0)
			return (drift == DRIFT_UP) ? 16'sh7FFF : 16'sh8000;
		return random_reading();
	endfunction

	function automatic igt_in_t random_sample(drift_e drift);
		igt_in_t s;
		s.accel_x = random_reading();
		s.accel_y = random_reading();
		s.accel_z = random_reading();
		s.rate_x  = rate_reading(drift);
		s.rate_y  = rate_reading(drift);
		s.rate_z  = rate_reading(drift);
		return s;
	endfunction

	function automatic igt_in_t sample_of(int ax, int ay, int az, int rx, int ry, int rz);
		igt_in_t s;
		s.accel_x = 16'(ax);
		s.accel_y = 16'(ay);
		s.accel_z = 16'(az);
		s.rate_x  = 16'(rx);
		s.rate_y  = 16'(ry);
		s.rate_z  = 16'(rz);
		return s;
	endfunction

	// Present one sample and hold it until accepted
	task automatic send_sample(igt_in_t s);
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_input(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic write_gain(logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every expected result has come back; the extra edge lets
	// the monitor note a sample accepted at the edge this was called on
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pred.pending() != 0) @(posedge clk);
	endtask

	// Bursts of random samples separated by random gaps
	task automatic run_random(int count, drift_e drift);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_sample(random_sample(drift));
				sent++;
			end
			pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70));
		end
	endtask

	initial begin
		pred = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at the reset gain
		send_sample(sample_of(0, 0, 0, 0, 0, 0));                 // zero over zero
		send_sample(sample_of(0, 1000, 0, 1, 1, 1));              // zero den, positive num
		send_sample(sample_of(0, -1000, 0, -1, -1, -1));          // zero den, negative num
		send_sample(sample_of(32767, 32767, 32767, 32767, 32767, 32767));
		send_sample(sample_of(-32768, -32768, -32768, -32768, -32768, -32768));
		send_sample(sample_of(-32768, 32767, 1, 32767, -32768, 1));
		send_sample(sample_of(5, 0, 5, 0, 0, 0));                 // zero num, nonzero den
		send_sample(sample_of(3, 32767, -1, 2, -2, 0));           // near right angle
		send_sample(sample_of(1, -1, -32768, 100, -100, 7));      // near zero angle
		send_sample(sample_of(100, -100, 100, -1, -1, -1));       // 45 degrees
		send_sample(sample_of(-1, -1, -1, 0, 32767, -32768));
		send_sample(sample_of(0, 0, -32768, 12345, -12345, 1));
		send_sample(sample_of(32767, -32768, 32767, 0, 0, 0));
		send_sample(sample_of(-32768, 0, 32767, -32768, 32767, 0));
		send_sample(sample_of(32767, 1, 0, 1, 0, -1));
		send_sample(sample_of(-7, 3, -4, 21845, -21846, 255));
		drain();

		write_gain('0);
		run_random(80, DRIFT_NONE);
		drain();

		write_gain(32'd1);
		run_random(150, DRIFT_NONE);
		drain();

		// Largest gain: drive accumulators into both saturation limits
		write_gain('1);
		run_random(350, DRIFT_UP);
		run_random(650, DRIFT_DOWN);
		drain();

		write_gain(32'($urandom()));
		run_random(250, DRIFT_NONE);
		drain();

		write_gain(GAIN_RESET);
		run_random(250, DRIFT_NONE);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pred.mismatches == 0 && pred.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
